[src/efcc_pkg.sv]
// Shared types, constants and the CRC-32 byte update for the frame CRC classifier.
// No dependencies; imported by efcc_classify and the top level.
package efcc_pkg;

	localparam int DEF_MIN_CRC_BYTES      = 16;
	localparam int DEF_MAX_FRAME_BYTES    = 255;
	localparam int DEF_MIN_CLASSIFY_BYTES = 64;

	localparam int HDR_BYTES = 42;

	localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
	localparam logic [31:0] CRC_GOOD       = 32'hDEBB20E3;
	localparam logic [31:0] CRC_SEED       = 32'hFFFFFFFF;
	localparam logic [31:0] LOCAL_IP_RESET = 32'hC0A80664;

	localparam logic [7:0] ETYPE_HI      = 8'h08;
	localparam logic [7:0] ETYPE_ARP_LO  = 8'h06;
	localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
	localparam logic [7:0] ARP_OP_REQ    = 8'h01;
	localparam logic [7:0] IP_PROTO_ICMP = 8'h01;
	localparam logic [7:0] ICMP_ECHO_REQ = 8'h08;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_ARP   = 2'd1,
		KIND_ICMP  = 2'd2
	} frame_kind_t;

	// byte i of the frame header is element i
	typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_t;

	typedef struct packed {
		frame_kind_t  kind;
		logic [47:0]  mac;
		logic [31:0]  ip;
	} peer_info_t;

	// Reflected CRC-32, one byte, bits taken LSB first
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[src/efcc_classify.sv]
// Header classifier: ARP request or ICMP echo request addressed to the local IP.
// Depends on efcc_pkg (header and result types, protocol constants).
module efcc_classify (
	input  logic                  en,
	input  efcc_pkg::hdr_bytes_t  hdr,
	input  logic [31:0]           local_ip,
	output efcc_pkg::peer_info_t  info
);
	import efcc_pkg::*;

	logic is_arp;
	logic is_icmp;

	assign is_arp = (hdr[12] == ETYPE_HI) && (hdr[13] == ETYPE_ARP_LO)
		&& (hdr[21] == ARP_OP_REQ)
		&& ({hdr[38], hdr[39], hdr[40], hdr[41]} == local_ip);

	assign is_icmp = (hdr[12] == ETYPE_HI) && (hdr[13] == ETYPE_IPV4_LO)
		&& (hdr[23] == IP_PROTO_ICMP)
		&& ({hdr[30], hdr[31], hdr[32], hdr[33]} == local_ip)
		&& (hdr[34] == ICMP_ECHO_REQ);

	always_comb begin
		info = '0;
		info.kind = KIND_OTHER;
		// ARP wins when both match
		if (en && is_arp) begin
			info.kind = KIND_ARP;
			info.mac  = {hdr[22], hdr[23], hdr[24], hdr[25], hdr[26], hdr[27]};
			info.ip   = {hdr[28], hdr[29], hdr[30], hdr[31]};
		end else if (en && is_icmp) begin
			info.kind = KIND_ICMP;
			info.mac  = {hdr[6], hdr[7], hdr[8], hdr[9], hdr[10], hdr[11]};
			info.ip   = {hdr[26], hdr[27], hdr[28], hdr[29]};
		end
	end

endmodule

[src/ethernet_frame_crc_classifier_core.sv]
// Top level of the Ethernet frame CRC check and classifier.
// Depends on efcc_pkg and efcc_classify.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    frame_byte, last
//  out       source     out_valid / out_ready  good_length, frame_kind, peer_mac, peer_ip
//  cfg       sink       cfg_wr_en              cfg_wr_data (local_ip)
//
// One byte per clock while the output is not stalled: a byte sits in the input register,
// where the CRC update, count and classifier run, and its result is then registered in
// the output register, which drives out_valid. The rate is set by the combinational
// CRC byte update feeding back into its own register.
// Reset seeds the CRC and clears the count, skip flag and valid bits; local_ip resets to 192.168.6.100.
// A stalled output holds the input register; the input still takes a byte while the
// result waits if that byte moves no further than the input register.
module ethernet_frame_crc_classifier_core #(
	parameter int MIN_CRC_BYTES      = efcc_pkg::DEF_MIN_CRC_BYTES,
	parameter int MAX_FRAME_BYTES    = efcc_pkg::DEF_MAX_FRAME_BYTES,
	parameter int MIN_CLASSIFY_BYTES = efcc_pkg::DEF_MIN_CLASSIFY_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  good_length,
	output logic [1:0]  frame_kind,
	output logic [47:0] peer_mac,
	output logic [31:0] peer_ip,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);
	import efcc_pkg::*;

	localparam int CNT_W     = $clog2(MAX_FRAME_BYTES + 1);
	localparam int HDR_IDX_W = $clog2(HDR_BYTES);

	logic [31:0]      local_ip_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [31:0]      crc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	hdr_bytes_t       hdr_q;

	logic             advance;
	logic [31:0]      crc_next;
	logic [CNT_W-1:0] cnt_next;
	logic             crc_hit;
	logic             at_max;
	logic             has_result;
	logic             hdr_wr;
	logic [31:0]      len32;
	logic             classify_en;
	hdr_bytes_t       hdr_view;
	peer_info_t       info;

	logic             out_valid_q;
	logic [7:0]       good_length_q;
	peer_info_t       info_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= LOCAL_IP_RESET;
		end else if (cfg_wr_en) begin
			local_ip_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= frame_byte;
			last_s1 <= last;
		end
	end

	assign crc_next = crc32_byte(crc_q, byte_s1);
	assign cnt_next = cnt_q + 1'b1;
	assign crc_hit  = (32'(cnt_next) >= 32'(MIN_CRC_BYTES)) && (crc_next == CRC_GOOD);
	assign at_max   = 32'(cnt_next) >= 32'(MAX_FRAME_BYTES);
	assign has_result  = !done_q && (crc_hit || last_s1 || at_max);
	assign len32       = crc_hit ? 32'(cnt_next) : 32'd0;
	assign classify_en = crc_hit && (32'(cnt_next) >= 32'(MIN_CLASSIFY_BYTES));
	assign hdr_wr      = !done_q && (32'(cnt_q) < 32'(HDR_BYTES));

	// forward the byte being stored so a short classify length sees it
	always_comb begin
		hdr_view = hdr_q;
		if (hdr_wr) begin
			hdr_view[cnt_q[HDR_IDX_W-1:0]] = byte_s1;
		end
	end

	efcc_classify u_classify (
		.en       (classify_en),
		.hdr      (hdr_view),
		.local_ip (local_ip_q),
		.info     (info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_SEED;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (advance) begin
			if (done_q || has_result) begin
				// a flagged last byte starts the next frame; otherwise drop until it
				if (last_s1) begin
					crc_q  <= CRC_SEED;
					cnt_q  <= '0;
					done_q <= 1'b0;
				end else begin
					done_q <= 1'b1;
				end
			end else begin
				crc_q <= crc_next;
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hdr_wr) begin
			hdr_q[cnt_q[HDR_IDX_W-1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			good_length_q <= len32[7:0];
			info_q        <= info;
		end
	end

	assign out_valid   = out_valid_q;
	assign good_length = good_length_q;
	assign frame_kind  = info_q.kind;
	assign peer_mac    = info_q.mac;
	assign peer_ip     = info_q.ip;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for ethernet_frame_crc_classifier_core: byte stream with random idling.
// Depends on efcc_pkg for types and constants; predicts CRC length and frame class per byte.
module tb_top;
	import efcc_pkg::*;

	localparam int MIN_CRC      = DEF_MIN_CRC_BYTES;
	localparam int MAX_FRAME    = DEF_MAX_FRAME_BYTES;
	localparam int MIN_CLASSIFY = DEF_MIN_CLASSIFY_BYTES;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef logic [7:0] octet_q_t[$];

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} rx_byte_t;

	typedef struct packed {
		logic [7:0]  len;
		frame_kind_t kind;
		logic [47:0] mac;
		logic [31:0] ip;
	} frame_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  frame_byte = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  good_length;
	logic [1:0]  frame_kind;
	logic [47:0] peer_mac;
	logic [31:0] peer_ip;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;

	rx_byte_t      bytes_to_send[$];
	frame_report_t frame_reports_due[$];
	frame_report_t want;

	// predictor state
	logic [31:0] ip_setting;
	logic [31:0] crc_acc;
	int          byte_cnt;
	logic        skip_rest;
	logic [7:0]  hdr_seen[HDR_BYTES];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int items_planned;
	int frames_planned;

	ethernet_frame_crc_classifier_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frame_byte(frame_byte),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.good_length(good_length),
		.frame_kind(frame_kind),
		.peer_mac(peer_mac),
		.peer_ip(peer_ip),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] crc_next(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = acc;
		for (int i = 0; i < 8; i++)
			r = (r >> 1) ^ ((r[0] ^ b[i]) ? CRC_POLY : 32'd0);
		return r;
	endfunction

	task automatic restart_frame();
		crc_acc = CRC_SEED;
		byte_cnt = 0;
		skip_rest = 1'b0;
	endtask

	task automatic predict_frame_report(input logic [7:0] b, input logic fin);
		frame_report_t rep;
		logic          found;
		if (skip_rest) begin
			if (fin)
				restart_frame();
			return;
		end
		if (byte_cnt < HDR_BYTES)
			hdr_seen[byte_cnt] = b;
		crc_acc = crc_next(crc_acc, b);
		byte_cnt++;
		found = (byte_cnt >= MIN_CRC) && (crc_acc == CRC_GOOD);
		if (!found && !fin && byte_cnt < MAX_FRAME)
			return;
		rep = '0;
		rep.len = found ? 8'(byte_cnt) : 8'd0;
		if (found && byte_cnt >= MIN_CLASSIFY) begin
			if (hdr_seen[12] == ETYPE_HI && hdr_seen[13] == ETYPE_ARP_LO &&
			    hdr_seen[21] == ARP_OP_REQ &&
			    {hdr_seen[38], hdr_seen[39], hdr_seen[40], hdr_seen[41]} == ip_setting) begin
				rep.kind = KIND_ARP;
				rep.mac = {hdr_seen[22], hdr_seen[23], hdr_seen[24],
				           hdr_seen[25], hdr_seen[26], hdr_seen[27]};
				rep.ip = {hdr_seen[28], hdr_seen[29], hdr_seen[30], hdr_seen[31]};
			end else if (hdr_seen[12] == ETYPE_HI && hdr_seen[13] == ETYPE_IPV4_LO &&
			             hdr_seen[23] == IP_PROTO_ICMP && hdr_seen[34] == ICMP_ECHO_REQ &&
			             {hdr_seen[30], hdr_seen[31], hdr_seen[32], hdr_seen[33]} == ip_setting) begin
				rep.kind = KIND_ICMP;
				rep.mac = {hdr_seen[6], hdr_seen[7], hdr_seen[8],
				           hdr_seen[9], hdr_seen[10], hdr_seen[11]};
				rep.ip = {hdr_seen[26], hdr_seen[27], hdr_seen[28], hdr_seen[29]};
			end
		end
		frame_reports_due.push_back(rep);
		if (fin)
			restart_frame();
		else
			skip_rest = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [47:0] exp_v,
	                           input logic [47:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Append FCS when asked, then trail bytes that follow the frame; last marks the final one.
	task automatic queue_frame(input octet_q_t body, input bit with_fcs, input int trail);
		logic [31:0] crc;
		crc = CRC_SEED;
		if (with_fcs) begin
			foreach (body[i])
				crc = crc_next(crc, body[i]);
			crc = ~crc;
			for (int k = 0; k < 4; k++)
				body.push_back(crc[8*k +: 8]);
		end
		items_planned += body.size();
		frames_planned++;
		foreach (body[i])
			bytes_to_send.push_back('{data: body[i],
			                          is_last: (trail == 0 && i == body.size() - 1)});
		for (int k = 0; k < trail; k++)
			bytes_to_send.push_back('{data: 8'($urandom), is_last: (k == trail - 1)});
	endtask

	function automatic octet_q_t make_request(input frame_kind_t k, input int body_len,
	                                          input bit spoil);
		octet_q_t f;
		int       key[$];
		int       ip_at;
		for (int i = 0; i < body_len; i++)
			f.push_back(8'($urandom));
		f[12] = ETYPE_HI;
		if (k == KIND_ARP) begin
			f[13] = ETYPE_ARP_LO;
			f[14] = 8'h00;
			f[15] = 8'h01;
			f[16] = ETYPE_HI;
			f[17] = ETYPE_IPV4_LO;
			f[18] = 8'h06;
			f[19] = 8'h04;
			f[20] = 8'h00;
			f[21] = ARP_OP_REQ;
			ip_at = 38;
			key = '{12, 13, 21, 38, 39, 40, 41};
		end else begin
			f[13] = ETYPE_IPV4_LO;
			f[14] = 8'h45;
			f[23] = IP_PROTO_ICMP;
			f[34] = ICMP_ECHO_REQ;
			ip_at = 30;
			key = '{12, 13, 23, 30, 31, 32, 33, 34};
		end
		for (int i = 0; i < 4; i++)
			f[ip_at + i] = ip_setting[31 - 8*i -: 8];
		// near miss: break one field the class depends on
		if (spoil)
			f[key[$urandom_range(key.size() - 1)]] ^= 8'($urandom_range(255, 1));
		return f;
	endfunction

	task automatic wait_drained();
		while (bytes_to_send.size() != 0 || frame_reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_local_ip(input logic [31:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		ip_setting = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// byte driver: hold the payload until transfer, then predict from what was taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			frame_byte <= '0;
			last <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_frame_report(frame_byte, last);
				void'(bytes_to_send.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					frame_byte <= bytes_to_send[0].data;
					last <= bytes_to_send[0].is_last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (frame_reports_due.size() == 0) begin
					$display("%0t: result with nothing due: length %0d kind %0d mac %h ip %h",
					         $time, good_length, frame_kind, peer_mac, peer_ip);
					mismatches++;
				end else begin
					want = frame_reports_due.pop_front();
					check_field("good_length", 48'(want.len), 48'(good_length));
					check_field("frame_kind", 48'(want.kind), 48'(frame_kind));
					check_field("peer_mac", want.mac, peer_mac);
					check_field("peer_ip", 48'(want.ip), 48'(peer_ip));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ethernet_frame_crc_classifier_core test failed");
			$finish;
		end
	end

	initial begin
		octet_q_t body;
		int       sel;
		int       trail;
		ip_setting = LOCAL_IP_RESET;
		restart_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			if (ph != 0) begin
				wait_drained();
				case (ph)
					1: write_local_ip(32'hFFFF_FFFF);
					2: write_local_ip(32'h0000_0000);
					default: write_local_ip($urandom);
				endcase
			end
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			@(negedge clk);
			if (ph == 0) begin
				// minimum length good frame, result mid-burst, then the rest is skipped
				body = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
				         8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h12, 8'h34};
				queue_frame(body, 1'b1, 2);
				// single byte bursts end with no CRC match
				body = '{8'hFF};
				queue_frame(body, 1'b0, 0);
				body = '{8'h00};
				queue_frame(body, 1'b0, 0);
				// run to the byte limit without a last flag
				body = {};
				repeat (MAX_FRAME) body.push_back(8'($urandom));
				queue_frame(body, 1'b0, 2);
			end
			items_planned = 0;
			frames_planned = 0;
			while (items_planned < 120 || frames_planned < 12) begin
				sel = $urandom_range(99);
				trail = $urandom_range(1) ? 0 : $urandom_range(4, 1);
				body = {};
				if (sel < 22) begin
					body = make_request(KIND_ARP, ($urandom_range(9) == 0) ?
					       $urandom_range(59, 42) : $urandom_range(75, 60),
					       $urandom_range(9) < 3);
					queue_frame(body, 1'b1, trail);
				end else if (sel < 44) begin
					body = make_request(KIND_ICMP, ($urandom_range(9) == 0) ?
					       $urandom_range(59, 42) : $urandom_range(75, 60),
					       $urandom_range(9) < 3);
					queue_frame(body, 1'b1, trail);
				end else if (sel < 66) begin
					repeat (($urandom_range(9) == 0) ? $urandom_range(251, 200) :
					        $urandom_range(26, 12))
						body.push_back(8'($urandom));
					queue_frame(body, 1'b1, trail);
				end else if (sel < 97) begin
					repeat ($urandom_range(20, 1)) body.push_back(8'($urandom));
					queue_frame(body, 1'b0, 0);
				end else begin
					repeat (MAX_FRAME) body.push_back(8'($urandom));
					queue_frame(body, 1'b0, $urandom_range(3, 1));
				end
			end
		end
		wait_drained();
		if (mismatches == 0)
			$display("ethernet_frame_crc_classifier_core test passed");
		else
			$display("ethernet_frame_crc_classifier_core test failed");
		$finish;
	end

endmodule
